/* hdl/periodic_box_minimum_image_assert.svh */
// periodic_box_minimum_image_assert.svh
// assertion macros for the periodic box unit, taken in by `include
// no dependencies
`ifndef PERIODIC_BOX_MINIMUM_IMAGE_ASSERT_SVH
`define PERIODIC_BOX_MINIMUM_IMAGE_ASSERT_SVH
`ifndef SYNTHESIS
`define PBMI_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("periodic box assertion failed");
`define PBMI_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("periodic box assertion failed");
`else
`define PBMI_ASSERT(lbl, clk, rst, prop)
`define PBMI_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* hdl/pbmi_pkg.sv */
// pbmi_pkg.sv
// widths, codes, lane types and pipeline depths for the periodic box unit
// no dependencies
package pbmi_pkg;

  localparam int COORD_W    = 32;
  localparam int LEN_W      = 30;
  localparam int LB_W       = 31;
  localparam int CMD_W      = 2;
  localparam int IMG_W      = 6;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam int IN_FIELDS_W = 6 * COORD_W + IMG_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((3 * COORD_W + 7) / 8) * 8;

  // difference a - b, then each fold grows the value by one bit
  localparam int DIFF_W  = COORD_W + 1;
  localparam int FOLD1_W = DIFF_W + 1;
  localparam int FOLD2_W = FOLD1_W + 1;

  localparam logic [LEN_W-1:0]       LEN_RESET = LEN_W'(65536);
  localparam logic signed [LB_W-1:0] LB_RESET  = -LB_W'(32768);

  // per axis image bits
  localparam int IMG_MINUS = 0;
  localparam int IMG_PLUS  = 1;

  // remainder steps of a fold on a dw-bit input, two quotient bits per stage
  function automatic int fold_steps(input int dw);
    return (dw + 2) / 2;
  endfunction

  localparam int FOLD1_LAT = fold_steps(DIFF_W) + 2;
  localparam int FOLD2_LAT = fold_steps(FOLD1_W) + 2;
  localparam int LANE_LAT  = 1 + FOLD1_LAT + FOLD2_LAT + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_DIFF  = 2'd0,
    CMD_MID   = 2'd1,
    CMD_IMAGE = 2'd2,
    CMD_PASS  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_IMAGE = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEN_X = 3'd0,
    CFG_LEN_Y = 3'd1,
    CFG_LEN_Z = 3'd2,
    CFG_LB_X  = 3'd3,
    CFG_LB_Y  = 3'd4,
    CFG_LB_Z  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] img;
  } lane_ctl_t;

  typedef struct packed {
    logic [COORD_W-1:0] value;
    logic               oor;
  } lane_res_t;

endpackage

/* hdl/pbmi_fold.sv */
// pbmi_fold.sv
// pipelined fold d - len * trunc(2d / len), restoring remainder two bits per stage
// depends on pbmi_pkg
module pbmi_fold #(
  parameter int DW = 33
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [pbmi_pkg::LEN_W-1:0]      len,
  input  logic signed [DW-1:0]            din,
  output logic signed [DW:0]              dout
);

  localparam int NSTEP = pbmi_pkg::fold_steps(DW);
  localparam int PW    = 2 * NSTEP;
  localparam int LW    = pbmi_pkg::LEN_W;
  localparam int OW    = DW + 1;

  logic [PW-1:0]        bits_q [0:NSTEP-1];
  logic [LW-1:0]        rem_q  [0:NSTEP];
  logic                 sign_q [0:NSTEP];
  logic signed [DW-1:0] d_q    [0:NSTEP];

  logic [DW-1:0]        mag;
  logic [LW-1:0]        rem_next [1:NSTEP];
  logic signed [OW-1:0] rem_s;
  logic signed [OW-1:0] dout_next;

  // magnitude of din, the most negative value maps onto its own pattern
  assign mag = din[DW-1] ? (~din + 1'b1) : din;

  always_comb begin
    logic [LW:0] t1, s1, t2, s2;
    t1 = '0;
    s1 = '0;
    t2 = '0;
    s2 = '0;
    for (int k = 1; k <= NSTEP; k++) begin
      t1 = {rem_q[k-1], bits_q[k-1][PW-1]};
      s1 = (t1 >= {1'b0, len}) ? t1 - {1'b0, len} : t1;
      t2 = {s1[LW-1:0], bits_q[k-1][PW-2]};
      s2 = (t2 >= {1'b0, len}) ? t2 - {1'b0, len} : t2;
      rem_next[k] = s2[LW-1:0];
    end
  end

  // remainder takes the sign of 2d, then fold = rem - d
  always_comb begin
    rem_s = signed'(OW'(rem_q[NSTEP]));
    if (len == '0) begin
      dout_next = OW'(d_q[NSTEP]);
    end else if (sign_q[NSTEP]) begin
      dout_next = -rem_s - OW'(d_q[NSTEP]);
    end else begin
      dout_next = rem_s - OW'(d_q[NSTEP]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bits_q[0] <= PW'({mag, 1'b0});
      rem_q[0]  <= '0;
      sign_q[0] <= din[DW-1];
      d_q[0]    <= din;
      for (int k = 1; k <= NSTEP; k++) begin
        rem_q[k]  <= rem_next[k];
        sign_q[k] <= sign_q[k-1];
        d_q[k]    <= d_q[k-1];
      end
      for (int k = 1; k < NSTEP; k++) begin
        bits_q[k] <= bits_q[k-1] << 2;
      end
      dout <= dout_next;
    end
  end

endmodule

/* hdl/pbmi_lane.sv */
// pbmi_lane.sv
// one axis: difference, two folds, midpoint or image shift, wrap and saturation
// depends on pbmi_pkg and pbmi_fold
module pbmi_lane (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [pbmi_pkg::LEN_W-1:0]             len,
  input  logic signed [pbmi_pkg::LB_W-1:0]       lb,
  input  pbmi_pkg::lane_ctl_t                    ctl,
  input  logic signed [pbmi_pkg::COORD_W-1:0]    a,
  input  logic signed [pbmi_pkg::COORD_W-1:0]    b,
  output pbmi_pkg::lane_res_t                    res
);

  localparam int CW  = pbmi_pkg::COORD_W;
  localparam int DFW = pbmi_pkg::DIFF_W;
  localparam int F1W = pbmi_pkg::FOLD1_W;
  localparam int F2W = pbmi_pkg::FOLD2_W;
  localparam int DLY = pbmi_pkg::FOLD1_LAT + pbmi_pkg::FOLD2_LAT;
  localparam int V_W = F2W + 1;
  localparam int W_W = V_W + 1;

  localparam logic signed [W_W-1:0] SAT_HI =
    {{(W_W - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [W_W-1:0] SAT_LO =
    {{(W_W - CW + 1){1'b1}}, {(CW - 1){1'b0}}};

  typedef struct packed {
    logic [CW-1:0]       a;
    pbmi_pkg::lane_ctl_t ctl;
    logic                oor;
  } pay_t;

  logic signed [DFW-1:0] dd, lim;
  logic                  oor_next;
  logic signed [DFW-1:0] d0;
  pay_t                  pay_q [0:DLY];

  logic signed [F1W-1:0] f1;
  logic signed [F2W-1:0] f2;

  logic signed [V_W-1:0] a_v, len_v, val_next, val1;
  pbmi_pkg::cmd_t        cmd1;
  logic                  oor1;

  logic signed [W_W-1:0] m, lo, hi, len_w, w;
  pbmi_pkg::lane_res_t   res_next;

  // difference and range check
  always_comb begin
    dd  = DFW'(a) - DFW'(b);
    lim = signed'(DFW'({len, 1'b0}));
    oor_next = (ctl.cmd == pbmi_pkg::CMD_DIFF || ctl.cmd == pbmi_pkg::CMD_MID) &&
               (dd > lim || dd < -lim);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0            <= dd;
      pay_q[0].a    <= a;
      pay_q[0].ctl  <= ctl;
      pay_q[0].oor  <= oor_next;
      for (int k = 1; k <= DLY; k++) begin
        pay_q[k] <= pay_q[k-1];
      end
    end
  end

  pbmi_fold #(.DW(DFW)) u_fold1 (
    .clk  (clk),
    .en   (en),
    .len  (len),
    .din  (d0),
    .dout (f1)
  );

  pbmi_fold #(.DW(F1W)) u_fold2 (
    .clk  (clk),
    .en   (en),
    .len  (len),
    .din  (f1),
    .dout (f2)
  );

  // command select: folded difference, midpoint sum, image shift or pass
  always_comb begin
    a_v   = V_W'(signed'(pay_q[DLY].a));
    len_v = V_W'(signed'({1'b0, len}));
    case (pay_q[DLY].ctl.cmd)
      pbmi_pkg::CMD_DIFF:  val_next = V_W'(f2);
      pbmi_pkg::CMD_MID:   val_next = a_v + V_W'(f2 >>> 1);
      pbmi_pkg::CMD_IMAGE: begin
        if (pay_q[DLY].ctl.img[pbmi_pkg::IMG_MINUS]) begin
          val_next = a_v - len_v;
        end else if (pay_q[DLY].ctl.img[pbmi_pkg::IMG_PLUS]) begin
          val_next = a_v + len_v;
        end else begin
          val_next = a_v;
        end
      end
      pbmi_pkg::CMD_PASS:  val_next = a_v;
      default:             val_next = a_v;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val1 <= val_next;
      cmd1 <= pay_q[DLY].ctl.cmd;
      oor1 <= pay_q[DLY].oor;
    end
  end

  // wrap midpoint once into the box, then saturate
  always_comb begin
    m     = W_W'(val1);
    lo    = W_W'(lb);
    len_w = W_W'(signed'({1'b0, len}));
    hi    = lo + len_w;
    if (cmd1 == pbmi_pkg::CMD_MID && m < lo) begin
      w = m + len_w;
    end else if (cmd1 == pbmi_pkg::CMD_MID && m >= hi) begin
      w = m - len_w;
    end else begin
      w = m;
    end
    if (w > SAT_HI) begin
      res_next.value = SAT_HI[CW-1:0];
    end else if (w < SAT_LO) begin
      res_next.value = SAT_LO[CW-1:0];
    end else begin
      res_next.value = w[CW-1:0];
    end
    res_next.oor = oor1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

/* hdl/periodic_box_minimum_image.sv */
// Periodic orthorhombic box unit. Takes one item per cycle on the input stream
// and returns one result per item, in order, through 42 pipeline stages plus
// the output register. The depth comes from the two folds on each axis, each a
// restoring remainder pipeline that resolves two quotient bits per stage
// against the box length; x, y and z run in three lanes side by side and the
// output stage merges their range flags into the status. The pipeline stalls
// as a whole only when its last stage holds an item and the output register
// holds an untaken result. The configuration port is always ready; the user must
// write box lengths and lower bounds only while idle; it is not enforced.
`include "periodic_box_minimum_image_assert.svh"

module periodic_box_minimum_image (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z, image_code
  input  logic [pbmi_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // command
  input  logic [pbmi_pkg::CMD_W-1:0]           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // result_x, result_y, result_z
  output logic [pbmi_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // status
  output logic [pbmi_pkg::STATUS_W-1:0]        m_axis_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pbmi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pbmi_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW   = pbmi_pkg::COORD_W;
  localparam int LAT  = pbmi_pkg::LANE_LAT;
  localparam int LAST = LAT - 1;

  logic [pbmi_pkg::LEN_W-1:0]       box_len [0:2];
  logic signed [pbmi_pkg::LB_W-1:0] box_low [0:2];

  logic [LAT-1:0]                   pipe_v;
  logic [LAT-1:0]                   noimg_q;
  logic                             adv;
  logic                             noimg_next;
  logic [pbmi_pkg::IMG_W-1:0]       image_code;

  pbmi_pkg::lane_res_t              lane_res [0:2];
  pbmi_pkg::status_t                status_next;
  logic                             out_valid;
  logic [pbmi_pkg::OUT_DATA_W-1:0]  out_data;
  pbmi_pkg::status_t                out_status;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        box_len[i] <= pbmi_pkg::LEN_RESET;
        box_low[i] <= pbmi_pkg::LB_RESET;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pbmi_pkg::CFG_LEN_X: box_len[0] <= cfg_data[pbmi_pkg::LEN_W-1:0];
        pbmi_pkg::CFG_LEN_Y: box_len[1] <= cfg_data[pbmi_pkg::LEN_W-1:0];
        pbmi_pkg::CFG_LEN_Z: box_len[2] <= cfg_data[pbmi_pkg::LEN_W-1:0];
        pbmi_pkg::CFG_LB_X:  box_low[0] <= signed'(cfg_data[pbmi_pkg::LB_W-1:0]);
        pbmi_pkg::CFG_LB_Y:  box_low[1] <= signed'(cfg_data[pbmi_pkg::LB_W-1:0]);
        pbmi_pkg::CFG_LB_Z:  box_low[2] <= signed'(cfg_data[pbmi_pkg::LB_W-1:0]);
        default: ;
      endcase
    end
  end

  // pipeline moves unless its last stage is blocked by an untaken result
  assign adv           = !pipe_v[LAST] || !out_valid || m_axis_tready;
  assign s_axis_tready = adv;

  assign image_code = s_axis_tdata[6*CW +: pbmi_pkg::IMG_W];
  assign noimg_next = (s_axis_tuser == pbmi_pkg::CMD_IMAGE) && (image_code == '0);

  for (genvar i = 0; i < 3; i++) begin : g_lane
    pbmi_pkg::lane_ctl_t ctl;
    assign ctl.cmd = pbmi_pkg::cmd_t'(s_axis_tuser);
    assign ctl.img = image_code[2*i +: 2];

    pbmi_lane u_lane (
      .clk (clk),
      .en  (adv),
      .len (box_len[i]),
      .lb  (box_low[i]),
      .ctl (ctl),
      .a   (signed'(s_axis_tdata[i*CW +: CW])),
      .b   (signed'(s_axis_tdata[(3+i)*CW +: CW])),
      .res (lane_res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v <= '0;
    end else if (adv) begin
      pipe_v <= {pipe_v[LAT-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      noimg_q <= {noimg_q[LAT-2:0], noimg_next};
    end
  end

  // merge of the no-image flag and the lane range flags; no-image wins
  always_comb begin
    if (noimg_q[LAST]) begin
      status_next = pbmi_pkg::STATUS_NO_IMAGE;
    end else if (lane_res[0].oor || lane_res[1].oor || lane_res[2].oor) begin
      status_next = pbmi_pkg::STATUS_RANGE;
    end else begin
      status_next = pbmi_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pipe_v[LAST] && adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_v[LAST] && adv) begin
      out_data   <= pbmi_pkg::OUT_DATA_W'({lane_res[2].value, lane_res[1].value,
                                           lane_res[0].value});
      out_status <= status_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_status;

  `PBMI_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (!m_axis_tvalid && pipe_v == '0))
  `PBMI_ASSERT(a_accept_enters, clk, rst, s_axis_tvalid && s_axis_tready |=> pipe_v[0])
  `PBMI_ASSERT(a_stall_holds, clk, rst, pipe_v[LAST] && !adv |=> pipe_v[LAST] && $stable(lane_res[0].value))

endmodule
